[rtl/core/pspc_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pspc_pkg
// Shared types and codes for the periodic sampling phase controller.
// ---------------------------------------------------------------------------
package pspc_pkg;

   localparam int CPI_W = 39;

   typedef enum logic [2:0] {
      KIND_SET_CPI  = 3'd0,
      KIND_FF_ON    = 3'd1,
      KIND_FF_OFF   = 3'd2,
      KIND_RESET    = 3'd3,
      KIND_NOTHING  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      REG_DETAILED  = 3'd0,
      REG_FF        = 3'd1,
      REG_SYNC      = 3'd2,
      REG_WARMUP    = 3'd3,
      REG_DWARMUP   = 3'd4,
      REG_DSYNC     = 3'd5,
      REG_DISPATCH  = 3'd6,
      REG_ONEIPC    = 3'd7
   } reg_type;

   // divider control bundle
   typedef struct packed {
      logic        start;
      logic [39:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [39:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

[rtl/core/pspc_divider.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pspc_divider
// Radix-2 restoring divider, one quotient bit per cycle, 40-bit quotient.
// ---------------------------------------------------------------------------
module pspc_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pspc_pkg::div_req_type div_req,
   output      pspc_pkg::div_rsp_type div_rsp
);
   import pspc_pkg::*;

   logic [39:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[39]};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = 6'd40;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[38:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[38:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule
`default_nettype wire

[rtl/core/periodic_sampling_phase_controller.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// periodic_sampling_phase_controller
// Detailed / fast-forward / warmup phase sequencer with per-core CPI history.
// ---------------------------------------------------------------------------
// Usage: requests enter on req_* (tvalid/tready); tuser is the operation
// (0 detailed tick, 1 fast-forward tick), tdata holds now_time, then the four
// measured CPIs, then the four core periods. Responses leave on rsp_*, with
// tlast marking the final response of a request. The user must write the
// registers on the csr_ APB port only while the block is idle (not enforced).
// Flow: a fast-forward tick passes from acceptance through the decide and chunk
// states, and through the tail state too when it ends with the reset/disable
// pair, then waits until its last response is taken. A detailed tick that ends
// an interval takes per core a push step, a read and an add step per held
// history entry to sum the ring, and two passes of the shared serial divider
// (mean, then period over dispatch width); an empty ring skips the mean pass,
// one-IPC mode skips both.
// req_tready is low from acceptance until the last response, if any, is taken;
// while the receiver stalls, the held response stays on rsp_tdata.
// Reset clears the phase state and the history fill counts; the history
// memory itself is not cleared, unwritten entries are never read.
// ---------------------------------------------------------------------------
module periodic_sampling_phase_controller #(
   parameter int CORES         = 4,
   parameter int HISTORY_DEPTH = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output      logic          req_tready,
   // now_time[63:0], measured_cpi_0..3, core_period_0..3
   input  wire logic [319:0]  req_tdata,
   // operation
   input  wire logic          req_tuser,
   output      logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   // core_number[1:0], cpi_value[40:2], until_time[104:41], warmup_chunk[105],
   // sync_flag[106], zero pad
   output      logic [111:0]  rsp_tdata,
   // result_kind
   output      logic [2:0]    rsp_tuser,
   output      logic          rsp_tlast,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [4:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output      logic [31:0]   csr_prdata,
   output      logic          csr_pready
);
   import pspc_pkg::*;

   localparam int CW = (CORES > 1) ? $clog2(CORES) : 1;
   localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FW = $clog2(HISTORY_DEPTH + 1);
   localparam int AW = (CORES * HISTORY_DEPTH > 1) ? $clog2(CORES * HISTORY_DEPTH) : 1;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_DECIDE = 11'b00000000010,
      ST_PUSH   = 11'b00000000100,
      ST_SUM    = 11'b00000001000,
      ST_MEAN   = 11'b00000010000,
      ST_LOW    = 11'b00000100000,
      ST_CLAMP  = 11'b00001000000,
      ST_CHUNK  = 11'b00010000000,
      ST_OUT    = 11'b00100000000,
      ST_WAITD  = 11'b01000000000,
      ST_TAIL   = 11'b10000000000
   } state_type;

   // configuration
   logic [31:0] det_int_ff, ff_int_ff, sync_int_ff, warm_int_ff, dwarm_int_ff;
   logic        dsync_ff, one_ipc_ff;
   logic [4:0]  disp_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         det_int_ff   <= '0;
         ff_int_ff    <= '0;
         sync_int_ff  <= 32'd1;
         warm_int_ff  <= '0;
         dwarm_int_ff <= '0;
         dsync_ff     <= 1'b0;
         disp_ff      <= 5'd4;
         one_ipc_ff   <= 1'b0;
      end else if (csr_wr && csr_paddr[1:0] == 2'b00) begin
         case (reg_type'(csr_idx))
            REG_DETAILED: det_int_ff   <= csr_pwdata;
            REG_FF:       ff_int_ff    <= csr_pwdata;
            REG_SYNC:     sync_int_ff  <= csr_pwdata;
            REG_WARMUP:   warm_int_ff  <= csr_pwdata;
            REG_DWARMUP:  dwarm_int_ff <= csr_pwdata;
            REG_DSYNC:    dsync_ff     <= csr_pwdata[0];
            REG_DISPATCH: disp_ff      <= csr_pwdata[4:0];
            REG_ONEIPC:   one_ipc_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_type'(csr_idx))
         REG_DETAILED: csr_prdata = det_int_ff;
         REG_FF:       csr_prdata = ff_int_ff;
         REG_SYNC:     csr_prdata = sync_int_ff;
         REG_WARMUP:   csr_prdata = warm_int_ff;
         REG_DWARMUP:  csr_prdata = dwarm_int_ff;
         REG_DSYNC:    csr_prdata = {31'd0, dsync_ff};
         REG_DISPATCH: csr_prdata = {27'd0, disp_ff};
         REG_ONEIPC:   csr_prdata = {31'd0, one_ipc_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // state
   state_type   st_ff, st_in;
   logic [63:0] pstart_ff, pstart_in;
   logic [32:0] ffleft_ff, ffleft_in;
   logic [31:0] wleft_ff, wleft_in;
   logic        pend_ff, pend_in;
   logic [FW-1:0] fill_ff [CORES];
   logic [HW-1:0] head_ff [CORES];
   logic [31:0] hist_mem [CORES*HISTORY_DEPTH];

   logic        op_ff;
   logic [319:0] dat_ff;
   logic [CW-1:0] core_ff, core_in;
   logic [HW-1:0] idx_ff, idx_in;
   logic [39:0] acc_ff, acc_in;
   logic [39:0] cpi_ff, cpi_in;
   logic [1:0]  tailn_ff, tailn_in;

   // output register
   logic        ov_ff, ov_in;
   kind_type    okind_ff, okind_in;
   logic [CW-1:0] ocore_ff, ocore_in;
   logic [38:0] ocpi_ff, ocpi_in;
   logic [63:0] ountil_ff, ountil_in;
   logic        owarm_ff, owarm_in, osync_ff, osync_in, olast_ff, olast_in;

   // history read and write ports
   logic [31:0] rd_data_ff;
   logic        wr_en;
   logic [31:0] wr_data;
   logic [AW-1:0] wr_addr, rd_addr;

   div_req_type div_req;
   div_rsp_type div_rsp;

   pspc_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   logic [63:0] now;
   logic [31:0] meas, per;
   logic        past;
   logic [32:0] sync_eff;
   logic [32:0] chunk;
   logic [4:0]  dw_eff;
   logic [38:0] hi_bound;
   logic        meas_ok;

   assign now  = dat_ff[63:0];
   assign meas = dat_ff[64 + 32*core_ff +: 32];
   assign per  = dat_ff[192 + 32*core_ff +: 32];
   assign meas_ok  = (meas != 32'd0) && (meas != 32'hFFFF_FFFF);
   assign sync_eff = (sync_int_ff == 32'd0) ? 33'd1 : {1'b0, sync_int_ff};
   assign dw_eff   = (disp_ff == 5'd0) ? 5'd1 : disp_ff;
   assign hi_bound = {7'd0, per} * 39'd100;

   always_comb begin
      logic [64:0] s;
      s    = {1'b0, pstart_ff} + {33'd0, det_int_ff};
      past = !s[64] && (now > s[63:0]);
   end

   logic dw_past;
   always_comb begin
      logic [64:0] s;
      s       = {1'b0, pstart_ff} + {33'd0, dwarm_int_ff};
      dw_past = !s[64] && (now > s[63:0]);
   end

   always_comb begin
      chunk = '0;
      if (ffleft_ff != '0)
         chunk = (ffleft_ff < sync_eff) ? ffleft_ff : sync_eff;
      else
         chunk = ({1'b0, wleft_ff} < sync_eff) ? {1'b0, wleft_ff} : sync_eff;
   end

   assign wr_addr = AW'(core_ff * HISTORY_DEPTH + head_ff[core_ff]);
   assign rd_addr = AW'(core_ff * HISTORY_DEPTH + idx_ff);
   assign wr_data = meas;

   always_ff @(posedge clock) begin
      if (wr_en)
         hist_mem[wr_addr] <= wr_data;
      rd_data_ff <= hist_mem[rd_addr];
   end

   logic        accept;
   assign req_tready = (st_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      st_in     = st_ff;
      pstart_in = pstart_ff;
      ffleft_in = ffleft_ff;
      wleft_in  = wleft_ff;
      pend_in   = pend_ff;
      core_in   = core_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      cpi_in    = cpi_ff;
      tailn_in  = tailn_ff;
      ov_in     = ov_ff;
      okind_in  = okind_ff;
      ocore_in  = ocore_ff;
      ocpi_in   = ocpi_ff;
      ountil_in = ountil_ff;
      owarm_in  = owarm_ff;
      osync_in  = osync_ff;
      olast_in  = olast_ff;
      wr_en     = 1'b0;
      div_req   = '0;
      if (ov_ff && rsp_tready)
         ov_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               st_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            core_in = '0;
            if (!op_ff) begin
               if (past) begin
                  pend_in   = 1'b0;
                  ffleft_in = {1'b0, ff_int_ff};
                  wleft_in  = warm_int_ff;
                  st_in     = ST_PUSH;
               end else if (pend_ff && dw_past) begin
                  pend_in   = 1'b0;
                  ov_in     = 1'b1;
                  okind_in  = KIND_RESET;
                  ocore_in  = '0;
                  ocpi_in   = '0;
                  ountil_in = '0;
                  owarm_in  = 1'b0;
                  osync_in  = 1'b0;
                  olast_in  = 1'b1;
                  st_in     = ST_WAITD;
               end else begin
                  st_in = ST_IDLE;
               end
            end else begin
               st_in   = ST_CHUNK;
            end
         end
         ST_PUSH: begin
            if (one_ipc_ff) begin
               cpi_in = {8'd0, per};
               st_in  = ST_OUT;
            end else begin
               if (meas_ok) begin
                  wr_en = 1'b1;
               end
               idx_in = '0;
               acc_in = '0;
               st_in  = ST_SUM;
            end
         end
         ST_SUM: begin
            // each entry is read, then added from the registered data in the next cycle
            if (fill_ff[core_ff] == '0) begin
               cpi_in = {8'd0, per};
               div_req.start    = 1'b1;
               div_req.dividend = {8'd0, per};
               div_req.divisor  = {27'd0, dw_eff};
               st_in = ST_LOW;
            end else begin
               if (tailn_ff == 2'd1)
                  acc_in = acc_ff + {8'd0, rd_data_ff};
               if (tailn_ff == 2'd1 &&
                   FW'(idx_ff) == fill_ff[core_ff] - FW'(1)) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = acc_ff + {8'd0, rd_data_ff};
                  div_req.divisor  = {{(32-FW){1'b0}}, fill_ff[core_ff]};
                  tailn_in = 2'd0;
                  st_in    = ST_MEAN;
               end else if (tailn_ff == 2'd1) begin
                  idx_in   = idx_ff + HW'(1);
                  tailn_in = 2'd0;
               end else begin
                  tailn_in = 2'd1;
               end
            end
         end
         ST_MEAN: begin
            if (div_rsp.done) begin
               cpi_in = div_rsp.quotient;
               div_req.start    = 1'b1;
               div_req.dividend = {8'd0, per};
               div_req.divisor  = {27'd0, dw_eff};
               st_in = ST_LOW;
            end
         end
         ST_LOW: begin
            if (div_rsp.done) begin
               if (cpi_ff < div_rsp.quotient)
                  cpi_in = div_rsp.quotient;
               else if (cpi_ff > {1'b0, hi_bound})
                  cpi_in = {1'b0, hi_bound};
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in     = 1'b1;
               okind_in  = KIND_SET_CPI;
               ocore_in  = core_ff;
               ocpi_in   = cpi_ff[38:0];
               ountil_in = '0;
               owarm_in  = 1'b0;
               osync_in  = 1'b0;
               olast_in  = 1'b0;
               if (core_ff == CW'(CORES - 1)) begin
                  st_in = ST_CHUNK;
               end else begin
                  core_in = core_ff + CW'(1);
                  st_in   = ST_PUSH;
               end
            end
         end
         ST_CHUNK: begin
            if (!ov_ff || rsp_tready) begin
               ov_in    = 1'b1;
               ocore_in = '0;
               ocpi_in  = '0;
               owarm_in = 1'b0;
               osync_in = 1'b0;
               ountil_in = '0;
               if (ffleft_ff != '0 || wleft_ff != '0) begin
                  okind_in  = KIND_FF_ON;
                  ountil_in = now + {31'd0, chunk};
                  owarm_in  = (ffleft_ff == '0);
                  osync_in  = dsync_ff;
                  olast_in  = 1'b1;
                  if (ffleft_ff != '0)
                     ffleft_in = ffleft_ff - chunk;
                  else
                     wleft_in = wleft_ff - chunk[31:0];
                  if (!op_ff)
                     pstart_in = now;
                  st_in = ST_WAITD;
               end else if (!op_ff) begin
                  okind_in  = KIND_NOTHING;
                  olast_in  = 1'b1;
                  pstart_in = now;
                  st_in     = ST_WAITD;
               end else begin
                  okind_in  = KIND_RESET;
                  olast_in  = 1'b0;
                  pstart_in = now;
                  if (dwarm_int_ff != '0)
                     pend_in = 1'b1;
                  st_in = ST_TAIL;
               end
            end
         end
         ST_TAIL: begin
            if (!ov_ff || rsp_tready) begin
               ov_in    = 1'b1;
               okind_in = KIND_FF_OFF;
               olast_in = 1'b1;
               st_in    = ST_WAITD;
            end
         end
         ST_WAITD: begin
            if (!ov_ff || rsp_tready)
               st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_tuser;
         dat_ff <= req_tdata;
      end
      core_ff   <= core_in;
      idx_ff    <= idx_in;
      acc_ff    <= acc_in;
      cpi_ff    <= cpi_in;
      okind_ff  <= okind_in;
      ocore_ff  <= ocore_in;
      ocpi_ff   <= ocpi_in;
      ountil_ff <= ountil_in;
      owarm_ff  <= owarm_in;
      osync_ff  <= osync_in;
      olast_ff  <= olast_in;
      if (reset) begin
         st_ff     <= ST_IDLE;
         pstart_ff <= '0;
         ffleft_ff <= '0;
         wleft_ff  <= '0;
         pend_ff   <= 1'b0;
         ov_ff     <= 1'b0;
         tailn_ff  <= '0;
         for (int i = 0; i < CORES; i++) begin
            fill_ff[i] <= '0;
            head_ff[i] <= '0;
         end
      end else begin
         st_ff     <= st_in;
         pstart_ff <= pstart_in;
         ffleft_ff <= ffleft_in;
         wleft_ff  <= wleft_in;
         pend_ff   <= pend_in;
         ov_ff     <= ov_in;
         tailn_ff  <= tailn_in;
         if (wr_en) begin
            head_ff[core_ff] <= (head_ff[core_ff] == HW'(HISTORY_DEPTH - 1)) ?
                                '0 : head_ff[core_ff] + HW'(1);
            if (fill_ff[core_ff] != FW'(HISTORY_DEPTH))
               fill_ff[core_ff] <= fill_ff[core_ff] + FW'(1);
         end
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {5'd0, osync_ff, owarm_ff, ountil_ff, ocpi_ff,
                        2'(ocore_ff)};

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a response is pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted while busy");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      fill_ff[0] <= FW'(HISTORY_DEPTH))
      else $error("history fill overflow");
`endif
endmodule
`default_nettype wire
